@@ sv/tdpt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tdpt_pkg
// shared constants and types for the trial-division prime test
// ----------------------------------------------------------------------------
package tdpt_pkg;

	// default data width of the tested value
	localparam int TDPT_WIDTH = 32;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_WAIT,
		ST_FINISH
	} tdpt_state_t;

endpackage : tdpt_pkg
`default_nettype wire

@@ sv/tdpt_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tdpt_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tdpt_div #(
	parameter int WIDTH = tdpt_pkg::TDPT_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             done,
	output logic [WIDTH-1:0] quotient,
	output logic [WIDTH-1:0] remainder
);
	import tdpt_pkg::*;

	localparam int CW = $clog2(WIDTH + 1);

	logic [CW-1:0]    cnt_q;
	logic             done_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] dvs_q;

	logic [WIDTH:0]   rem_shift;
	logic [WIDTH:0]   rem_sub;
	logic             ge;

	// shift in next dividend bit, trial subtract
	assign rem_shift = {rem_q, quo_q[WIDTH-1]};
	assign ge        = rem_shift >= {1'b0, dvs_q};
	assign rem_sub   = rem_shift - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(WIDTH);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[WIDTH-2:0], ge};
			rem_q <= ge ? rem_sub[WIDTH-1:0] : rem_shift[WIDTH-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule : tdpt_div
`default_nettype wire

@@ sv/trial_division_prime_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_prime_test
// primality test of one signed integer by odd trial divisors
// ----------------------------------------------------------------------------
// Takes one signed WIDTH-bit value per input transfer and returns one flag,
// is_prime, per output transfer. Values below 2 (negatives included) give 0,
// two and three give 1, other even values give 0 from the parity check. Odd values
// from five up are divided by 3, 5, 7, ... on one shared restoring divider
// that yields one quotient bit per cycle; each trial is a start, WIDTH
// divider steps and a check. The search stops when the divisor exceeds the
// quotient (prime) or the remainder is zero (not prime), with trials up to
// about sqrt(value) / 2. One item is in work at a time and in_ready is low
// meanwhile; the result sits in an output register, so the next item can be
// taken while an earlier flag still waits for its transfer.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
	parameter int WIDTH = tdpt_pkg::TDPT_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [WIDTH-1:0] value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    is_prime
);
	import tdpt_pkg::*;

	tdpt_state_t      state_q, state_d;
	logic [WIDTH-1:0] v_q, v_d;       // value under test
	logic [WIDTH-1:0] d_q, d_d;       // current odd trial divisor
	logic             res_q, res_d;   // pending verdict
	logic             out_valid_q;
	logic             out_q;
	logic             load_out;
	logic             div_start;
	logic             div_done;
	logic [WIDTH-1:0] div_quo;
	logic [WIDTH-1:0] div_rem;
	logic [WIDTH-1:0] uval;

	assign uval = $unsigned(value);

	// shared divider: v_q / d_q
	tdpt_div #(
		.WIDTH(WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (v_q),
		.divisor  (d_q),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// sequencer
	always_comb begin
		state_d   = state_q;
		v_d       = v_q;
		d_d       = d_q;
		res_d     = res_q;
		div_start = 1'b0;
		load_out  = 1'b0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					v_d = uval;
					d_d = WIDTH'(3);
					priority if (value[WIDTH-1] || uval < WIDTH'(2)) begin
						// negative, zero or one
						res_d   = 1'b0;
						state_d = ST_FINISH;
					end else if (uval < WIDTH'(4)) begin
						// two and three
						res_d   = 1'b1;
						state_d = ST_FINISH;
					end else if (!uval[0]) begin
						res_d   = 1'b0;
						state_d = ST_FINISH;
					end else begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				div_start = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (div_done) begin
					priority if (d_q > div_quo) begin
						// divisor past the square root: no factor left
						res_d   = 1'b1;
						state_d = ST_FINISH;
					end else if (div_rem == '0) begin
						res_d   = 1'b0;
						state_d = ST_FINISH;
					end else begin
						d_d     = d_q + WIDTH'(2);
						state_d = ST_DIV;
					end
				end
			end
			ST_FINISH: begin
				// wait for the output register to be free
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		v_q   <= v_d;
		d_q   <= d_d;
		res_q <= res_d;
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign is_prime  = out_q;

	// the divider only finishes while the sequencer waits on it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_WAIT)
		else $error("divider done outside wait state");

	// negative values are rejected right away
	a_neg_reject: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && value[WIDTH-1] |=> state_q == ST_FINISH && !res_q)
		else $error("negative value not rejected");

	// only odd divisors are ever tried
	a_odd_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> d_q[0])
		else $error("even trial divisor");

	// an output load never overwrites a result still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !out_valid_q || out_ready)
		else $error("pending result overwritten");

endmodule : trial_division_prime_test
`default_nettype wire

@@ sim/trial_division_prime_test_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_prime_test_tb
// self-checking regression for the trial-division prime test
// ----------------------------------------------------------------------------
// Feeds signed values through the input channel and checks every returned
// is_prime flag against a predictor in this file, in order. A short table of
// corner values comes first: negatives, zero, one, two, three, squares of
// primes and the largest 31-bit prime. Random values follow in four phases
// of sender idling and receiver stalls. Random values are mostly small or
// have a small factor.
// ----------------------------------------------------------------------------
module trial_division_prime_test_tb;

	import tdpt_pkg::*;

	localparam int WIDTH = TDPT_WIDTH;

	// slowest correct run is the one for 2^31-1, plus stalls; this leaves a wide margin
	localparam int unsigned CYCLE_LIMIT = 12_000_000;
	localparam int RANDOM_PER_PHASE = 25;
	localparam int SETTLE_CYCLES = 200;
	localparam int MAX_REPORTS = 10;

	// one row of the directed table; flag is typed in only where has_flag is set
	typedef struct {
		logic signed [WIDTH-1:0] value;
		bit                      has_flag;
		logic                    flag;
	} probe_t;

	// one expected output transfer
	typedef struct {
		logic signed [WIDTH-1:0] value;
		logic                    flag;
	} verdict_t;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [WIDTH-1:0] value = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    is_prime;

	verdict_t    pending_verdicts [$];
	verdict_t    oldest;
	int          error_count = 0;
	int          values_sent = 0;
	int          flags_seen = 0;
	int          primes_seen = 0;
	int unsigned cycle_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	// corner values: sign extremes, zero and one, two and three where no divisor
	// is tried, squares of primes right on the divisor bound, and the top end
	probe_t directed_rows [21] = '{
		'{32'sh80000000, 1'b1, 1'b0},
		'{32'shFFFFFFFF, 1'b1, 1'b0},
		'{32'shFFFFFFFE, 1'b1, 1'b0},
		'{32'sh00000000, 1'b1, 1'b0},
		'{32'sh00000001, 1'b1, 1'b0},
		'{32'sh00000002, 1'b1, 1'b1},
		'{32'sh00000003, 1'b1, 1'b1},
		'{32'sh00000004, 1'b1, 1'b0},
		'{32'sd5,        1'b0, 1'b0},
		'{32'sd9,        1'b0, 1'b0},
		'{32'sd25,       1'b0, 1'b0},
		'{32'sd49,       1'b0, 1'b0},
		'{32'sd97,       1'b0, 1'b0},
		'{32'sd121,      1'b0, 1'b0},
		'{32'sd65537,    1'b0, 1'b0},
		'{32'sd1042441,  1'b0, 1'b0},
		'{32'sh55555555, 1'b0, 1'b0},
		'{32'sh40000000, 1'b0, 1'b0},
		'{32'sh7FFFFFFE, 1'b0, 1'b0},
		'{32'sh7FFFFFFD, 1'b0, 1'b0},
		'{32'sh7FFFFFFF, 1'b0, 1'b0}
	};

	trial_division_prime_test #(
		.WIDTH(WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_prime (is_prime)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop if the block hangs or the run is far slower than expected
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d flags still owed",
				cycle_count, pending_verdicts.size());
			$display("trial_division_prime_test regression: fail");
			$finish;
		end
	end

	// trial division on odd divisors, bounded by d <= n / d so it never overflows
	function automatic logic prime_flag(input logic signed [WIDTH-1:0] v);
		longint unsigned n;
		longint unsigned d;
		if (v < 2)
			return 1'b0;
		n = longint'(v);
		if (n < 4)
			return 1'b1;
		if (n[0] == 1'b0)
			return 1'b0;
		for (d = 3; d <= n / d; d += 2) begin
			if (n % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// mix of value classes; odd values above 2^21 always carry a small factor
	// so the divider finds it within a few dozen trials
	function automatic logic signed [WIDTH-1:0] random_value();
		int unsigned sel;
		int unsigned k;
		logic [31:0] r;
		sel = $urandom_range(99);
		r = $urandom;
		if (sel < 30) begin
			r = $urandom_range(4095);
		end else if (sel < 55) begin
			r = $urandom_range(65535, 4096);
		end else if (sel < 65) begin
			// negative: sign bit set, rest random
			r[31] = 1'b1;
		end else if (sel < 80) begin
			// large even value, stops after the parity check
			r[31] = 1'b0;
			r[0] = 1'b0;
		end else if (sel < 95) begin
			// large multiple of an odd number from 3 to 99
			r[31] = 1'b0;
			k = 2 * $urandom_range(49, 1) + 1;
			r = (r / k) * k;
		end else begin
			r = $urandom_range(32'h0020_0000, 32'h0010_0000);
		end
		return r;
	endfunction

	task automatic note_failure(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("mismatch %0d at cycle %0d: %s", error_count, cycle_count, msg);
	endtask

	// one input transfer: random idle cycles first, then hold valid until taken
	task automatic send_value(input logic signed [WIDTH-1:0] v, input logic flag);
		verdict_t entry;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do
			@(posedge clk);
		while (!in_ready);
		entry.value = v;
		entry.flag = flag;
		pending_verdicts = {pending_verdicts, entry};
		values_sent++;
	endtask

	// drop valid and hold off until every owed flag has come back
	task automatic drain_flags();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(negedge clk);
	endtask

	task automatic random_phase(input int idle_pct, input int stall_pct);
		logic signed [WIDTH-1:0] v;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (RANDOM_PER_PHASE) begin
			v = random_value();
			send_value(v, prime_flag(v));
		end
		drain_flags();
	endtask

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// output transfers are checked against the oldest owed flag
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			flags_seen++;
			if (is_prime === 1'b1)
				primes_seen++;
			if (pending_verdicts.size() == 0) begin
				note_failure($sformatf("flag %b with no value outstanding", is_prime));
			end else begin
				oldest = pending_verdicts.pop_front();
				if (is_prime !== oldest.flag)
					note_failure($sformatf("value %0d: is_prime expected %b, got %b",
						oldest.value, oldest.flag, is_prime));
			end
		end
	end

	initial begin
		// reset held low, then released away from the rising edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table with a free-running receiver
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (directed_rows[i])
			send_value(directed_rows[i].value, directed_rows[i].has_flag ?
				directed_rows[i].flag : prime_flag(directed_rows[i].value));
		// sender pauses here until the whole table has been answered
		drain_flags();

		// random values: no idling, sender idle, receiver stalling, both
		random_phase(0, 0);
		random_phase(81, 0);
		random_phase(0, 81);
		random_phase(26, 26);

		// nothing is owed now; any stray transfer in this window is flagged
		recv_stall_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("checked %0d flags for %0d values (%0d table rows, rest random), %0d prime",
			flags_seen, values_sent, $size(directed_rows), primes_seen);
		$display("random values ran with no idling, idle sender, stalled receiver and both; "
			, "%0d cycles", cycle_count);
		if (error_count == 0 && pending_verdicts.size() == 0)
			$display("trial_division_prime_test regression: pass");
		else
			$display("trial_division_prime_test regression: fail");
		$finish;
	end

endmodule : trial_division_prime_test_tb
`default_nettype wire
